// File: sv/triggered_sample_capture_assert.svh
// Assertion macros for the capture store; they use the clk and rst of the including module.
`ifndef TRIGGERED_SAMPLE_CAPTURE_ASSERT_SVH
`define TRIGGERED_SAMPLE_CAPTURE_ASSERT_SVH

// same-cycle implication
`define TSC_ASSERT_SAME(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tsc same-cycle check failed");

// next-cycle implication
`define TSC_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tsc next-cycle check failed");

`endif

// File: sv/tsc_pkg.sv
// Shared types, constants and the scaling function of the capture store.
package tsc_pkg;

  localparam int DEPTH    = 1024;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 10;
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 10;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [9:0] WINDOW_RESET = 10'd30;

  // x / 100 == (x * 41944) >> 22 for every x up to 2^15 (largest sample magnitude)
  localparam logic [15:0] SCALE_MUL   = 16'd41944;
  localparam int          SCALE_SHIFT = 22;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_PAUSE        = 2'd0,
    REG_TRIG_ENABLE  = 2'd1,
    REG_TRIG_LEVEL   = 2'd2,
    REG_TRIG_WINDOW  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              pause;
    logic              trig_en;
    logic signed [9:0] level;
    logic [9:0]        window;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic hit;
  } status_t;

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] data;
  } wr_req_t;

  // signed divide by 100, truncating toward zero
  function automatic logic signed [DATA_W-1:0] scale_sample(
    input logic signed [SAMPLE_W-1:0] s
  );
    logic [SAMPLE_W-1:0] mag;
    logic [31:0]         prod;
    logic [DATA_W-1:0]   q;
    mag  = s[SAMPLE_W-1] ? SAMPLE_W'(~s + 1'b1) : SAMPLE_W'(s);
    prod = mag * SCALE_MUL;
    q    = DATA_W'(prod >> SCALE_SHIFT);
    return $signed(s[SAMPLE_W-1] ? DATA_W'(~q + 1'b1) : q);
  endfunction

endpackage

// File: sv/tsc_capture.sv
// Capture control: fill count, write position, trigger flag and the store write request.
module tsc_capture import tsc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  cfg_t                       cfg,
  output wr_req_t                    wr,
  output logic                       written,
  output status_t                    now,
  output status_t                    after
);

  logic [CNT_W-1:0]  fill_count, fill_count_next;
  logic [ADDR_W-1:0] write_position, write_position_next;
  logic              hit_flag, hit_flag_next;

  logic signed [DATA_W-1:0] scaled;
  logic signed [11:0]       diff;
  logic [11:0]              gap;
  logic                     in_window;
  logic                     armed;
  logic                     filling;
  logic [ADDR_W-1:0]        pos_use;
  logic                     hit_use;
  logic                     we;
  logic [ADDR_W-1:0]        waddr;

  function automatic logic [ADDR_W-1:0] next_pos(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(DEPTH - 1)) ? '0 : ADDR_W'(p + 1'b1);
  endfunction

  assign scaled    = scale_sample(sample);
  assign diff      = 12'(scaled) - 12'(cfg.level);
  assign gap       = diff[11] ? 12'(-diff) : 12'(diff);
  assign in_window = (gap <= {2'b00, cfg.window});
  assign armed     = cfg.trig_en && !hit_flag;
  assign filling   = (fill_count != CNT_W'(DEPTH));

  // while armed the position is held at the start of the store
  assign pos_use = armed ? '0 : write_position;
  assign hit_use = armed ? in_window : hit_flag;

  always_comb begin
    fill_count_next     = fill_count;
    write_position_next = write_position;
    hit_flag_next       = hit_flag;
    we                  = 1'b0;
    waddr               = pos_use;
    if (step) begin
      if (filling) begin
        we                  = 1'b1;
        waddr               = fill_count[ADDR_W-1:0];
        fill_count_next     = CNT_W'(fill_count + 1'b1);
        write_position_next = next_pos(pos_use);
        hit_flag_next       = hit_use;
      end else begin
        we                  = !cfg.trig_en || hit_use;
        write_position_next = we ? next_pos(pos_use) : pos_use;
        // re-arm once the pass wraps back to the start
        hit_flag_next       = (write_position_next == '0) ? 1'b0 : hit_use;
      end
    end
  end

  assign wr      = '{we: we, addr: waddr, data: scaled};
  assign written = we;

  assign now   = '{full: !filling, hit: hit_flag};
  assign after = '{full: (fill_count_next == CNT_W'(DEPTH)), hit: hit_flag_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      write_position <= '0;
      hit_flag       <= 1'b0;
    end else begin
      fill_count     <= fill_count_next;
      write_position <= write_position_next;
      hit_flag       <= hit_flag_next;
    end
  end

endmodule

// File: sv/tsc_store.sv
// Sample memory: one write port, one enabled read port with registered data.
module tsc_store import tsc_pkg::*; (
  input  logic                     clk,
  input  wr_req_t                  wr,
  input  logic                     re,
  input  logic [ADDR_W-1:0]        raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/triggered_sample_capture.sv
// Triggered capture store top level: request pipeline, register port and checks.
// A request passes through the input register and then the result register; out_valid is the result register's valid.
// Throughput: one request per cycle; the input stalls only while both stages hold requests and out_ready is low.
// Reset (synchronous, rst high): clears the pipeline, fill count, write position,
// trigger flag and registers (window to 30); store contents are not cleared.
`include "triggered_sample_capture_assert.svh"

module triggered_sample_capture import tsc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [IDX_W-1:0]           read_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DATA_W-1:0]   read_data,
  output logic                       store_full,
  output logic                       written,
  output logic                       trigger_hit
);

  cfg_t     cfg;
  reg_idx_t reg_sel;

  logic                       a_vld;
  cmd_t                       a_cmd;
  logic signed [SAMPLE_W-1:0] a_sample;
  logic [IDX_W-1:0]           a_idx;
  logic                       adv;
  logic                       step;

  logic    b_vld;
  logic    b_read;
  logic    b_rd_ok;
  logic    b_written;
  logic    b_full;
  logic    b_hit;

  wr_req_t                  wr;
  logic                     cap_written;
  status_t                  now;
  status_t                  after;
  logic signed [DATA_W-1:0] rdata;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pause   <= 1'b0;
      cfg.trig_en <= 1'b0;
      cfg.level   <= '0;
      cfg.window  <= WINDOW_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_PAUSE:       cfg.pause   <= pwdata[0];
        REG_TRIG_ENABLE: cfg.trig_en <= pwdata[0];
        REG_TRIG_LEVEL:  cfg.level   <= $signed(pwdata[9:0]);
        REG_TRIG_WINDOW: cfg.window  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PAUSE:       prdata = {31'b0, cfg.pause};
      REG_TRIG_ENABLE: prdata = {31'b0, cfg.trig_en};
      REG_TRIG_LEVEL:  prdata = {22'b0, cfg.level};
      REG_TRIG_WINDOW: prdata = {22'b0, cfg.window};
      default:         prdata = '0;
    endcase
  end

  // request pipeline: input register, then result register
  assign adv      = a_vld && (!b_vld || out_ready);
  assign in_ready = !a_vld || adv;
  assign step     = adv && (a_cmd == CMD_SAMPLE) && !cfg.pause;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_vld <= 1'b1;
    end else if (adv) begin
      a_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_cmd    <= cmd_t'(command);
      a_sample <= sample;
      a_idx    <= read_index;
    end
  end

  tsc_capture u_capture (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .sample  (a_sample),
    .cfg     (cfg),
    .wr      (wr),
    .written (cap_written),
    .now     (now),
    .after   (after)
  );

  tsc_store u_store (
    .clk   (clk),
    .wr    (wr),
    .re    (adv),
    .raddr (ADDR_W'(a_idx)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= 1'b1;
    end else if (out_ready) begin
      b_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_read    <= (a_cmd == CMD_READ);
      b_rd_ok   <= (32'(a_idx) < 32'(DEPTH));
      b_written <= cap_written;
      b_full    <= after.full;
      b_hit     <= after.hit;
    end
  end

  assign out_valid   = b_vld;
  assign read_data   = (b_read && b_rd_ok) ? rdata : '0;
  assign store_full  = b_full;
  assign written     = b_written;
  assign trigger_hit = b_hit;

  `TSC_ASSERT_SAME(a_written_not_read, b_vld && b_written, !b_read)
  `TSC_ASSERT_NEXT(a_full_sticky, now.full, now.full)
  `TSC_ASSERT_NEXT(a_stage_held, a_vld && !adv, a_vld)
  `TSC_ASSERT_NEXT(a_read_keeps_state, adv && (a_cmd == CMD_READ),
                   $stable(now.full) && $stable(now.hit))

endmodule
